// ===== hw/rtl/mstt_pkg.sv =====
// Shared types and constants of the timer slot table.
// Item structs, request codes and controller/datapath handshake structs.
// No dependencies.
package mstt_pkg;

  // Table size and derived widths
  localparam int NUM_SLOTS = 8;
  localparam int IdxW      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int UsedW     = $clog2(NUM_SLOTS + 1);
  localparam int WideW     = (IdxW > 3) ? IdxW : 3;
  localparam int CmpW      = (UsedW > 3) ? UsedW : 3;
  localparam int MaskW     = 8;

  // Request codes
  localparam logic [2:0] REQ_START    = 3'd0;
  localparam logic [2:0] REQ_STOP     = 3'd1;
  localparam logic [2:0] REQ_TICK     = 3'd2;
  localparam logic [2:0] REQ_DISPATCH = 3'd3;
  localparam logic [2:0] REQ_CLEAR    = 3'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] delay_ticks;
    logic        periodic;
    logic [2:0]  slot_sel;
  } in_item_t;

  typedef struct packed {
    logic             status;
    logic [2:0]       slot_id;
    logic [MaskW-1:0] fired_mask;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic exec_single;
    logic scan_step;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_scan;
    logic scan_empty;
    logic scan_last;
  } dp_status_t;

endpackage

// ===== hw/rtl/mstt_ctrl.sv =====
// Controller state machine of the timer slot table.
// Sequences capture, single action or slot scan, and result hand-off.
// Depends on mstt_pkg.
module mstt_ctrl import mstt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dp_cmd_t    cmd_o,
  input  dp_status_t stat_i
);

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StScan,
    StResp
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  // Decode commands from the current state
  always_comb begin
    cmd_o             = '0;
    cmd_o.load        = (state_q == StIdle) && in_valid_i;
    cmd_o.exec_single = (state_q == StExec) && !stat_i.is_scan;
    cmd_o.scan_step   = (state_q == StScan);
    cmd_o.out_load    = (state_q == StResp) && (!out_valid_q || out_ready_i);
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q <= StExec;
          end
        end
        StExec: begin
          if (stat_i.is_scan && !stat_i.scan_empty) begin
            state_q <= StScan;
          end else begin
            state_q <= StResp;
          end
        end
        StScan: begin
          if (stat_i.scan_last) begin
            state_q <= StResp;
          end
        end
        StResp: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/mstt_datapath.sv =====
// Datapath of the timer slot table: slot storage, scan index and result.
// Acts on commands from mstt_ctrl and reports scan status back.
// Depends on mstt_pkg.
module mstt_datapath import mstt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   in_data_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t stat_o,
  output out_item_t  out_data_o
);

  // Slot storage: counts, delays and modes are written before they are read
  logic [15:0]      count_q [NUM_SLOTS];
  logic [15:0]      delay_q [NUM_SLOTS];
  logic             per_q   [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] run_q;
  logic [UsedW-1:0] used_q;

  in_item_t         req_q;
  logic [IdxW-1:0]  idx_q;
  logic             status_q;
  logic [2:0]       id_q;
  logic [MaskW-1:0] mask_q;
  out_item_t        out_q;

  logic             full;
  logic [IdxW-1:0]  new_idx;
  logic             sel_ok;
  logic [WideW-1:0] sel_wide;
  logic [IdxW-1:0]  sel_idx;
  logic [WideW-1:0] idx_wide;
  logic [15:0]      cur_count;
  logic [15:0]      cur_delay;
  logic             cur_hit;

  assign full      = (used_q == UsedW'(NUM_SLOTS));
  assign new_idx   = used_q[IdxW-1:0];
  assign sel_wide  = WideW'(req_q.slot_sel);
  assign sel_idx   = sel_wide[IdxW-1:0];
  assign sel_ok    = (CmpW'(req_q.slot_sel) < CmpW'(used_q));
  assign idx_wide  = WideW'(idx_q);
  assign cur_count = count_q[idx_q];
  assign cur_delay = delay_q[idx_q];
  assign cur_hit   = (cur_count == cur_delay);

  // Report scan status
  assign stat_o.is_scan    = (req_q.req_type == REQ_TICK) ||
                             (req_q.req_type == REQ_DISPATCH) ||
                             (req_q.req_type == REQ_CLEAR);
  assign stat_o.scan_empty = (used_q == '0);
  assign stat_o.scan_last  = ((UsedW'(idx_q) + UsedW'(1)) == used_q);

  assign out_data_o = out_q;

  // Update slot payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec_single) begin
      case (req_q.req_type)
        REQ_START: begin
          if (!full) begin
            count_q[new_idx] <= '0;
            delay_q[new_idx] <= req_q.delay_ticks;
            per_q[new_idx]   <= req_q.periodic;
          end
        end
        REQ_STOP: begin
          if (sel_ok && run_q[sel_idx]) begin
            count_q[sel_idx] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.scan_step) begin
      case (req_q.req_type)
        REQ_TICK: begin
          if (run_q[idx_q] && (cur_count < cur_delay)) begin
            count_q[idx_q] <= cur_count + 16'd1;
          end
        end
        REQ_DISPATCH: begin
          if (cur_hit) begin
            count_q[idx_q] <= '0;
          end
        end
        REQ_CLEAR: begin
          count_q[idx_q] <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Track allocation and run flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      used_q <= '0;
    end else begin
      if (cmd_i.exec_single) begin
        case (req_q.req_type)
          REQ_START: begin
            if (!full) begin
              run_q[new_idx] <= 1'b1;
              used_q         <= used_q + UsedW'(1);
            end
          end
          REQ_STOP: begin
            if (sel_ok && run_q[sel_idx]) begin
              run_q[sel_idx] <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.scan_step && (req_q.req_type == REQ_DISPATCH) &&
          cur_hit && !per_q[idx_q]) begin
        run_q[idx_q] <= 1'b0;
      end
    end
  end

  // Capture the item, build the result and advance the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q    <= in_data_i;
      idx_q    <= '0;
      status_q <= 1'b0;
      id_q     <= '0;
      mask_q   <= '0;
    end
    if (cmd_i.exec_single) begin
      case (req_q.req_type)
        REQ_START: begin
          if (full) begin
            status_q <= 1'b1;
          end else begin
            id_q <= 3'(used_q);
          end
        end
        REQ_STOP: begin
          if (!(sel_ok && run_q[sel_idx])) begin
            status_q <= 1'b1;
          end
        end
        default: begin
          status_q <= 1'b1;
        end
      endcase
    end
    if (cmd_i.scan_step) begin
      idx_q <= idx_q + IdxW'(1);
      if ((req_q.req_type == REQ_DISPATCH) && cur_hit &&
          (32'(idx_wide) < 32'(MaskW))) begin
        mask_q[idx_wide[2:0]] <= 1'b1;
      end
    end
    if (cmd_i.out_load) begin
      out_q.status     <= status_q;
      out_q.slot_id    <= id_q;
      out_q.fired_mask <= mask_q;
    end
  end

endmodule

// ===== hw/rtl/multi_slot_timer_table.sv =====
// Top level of the timer slot table: controller plus datapath.
// Depends on mstt_pkg, mstt_ctrl and mstt_datapath.
//
//   channel | signals                          | payload
//   --------+----------------------------------+-----------
//   input   | in_valid_i / in_ready_o          | in_item_t
//   output  | out_valid_o / out_ready_i        | out_item_t
//
// Start, stop and unknown requests pass from accept through the execute state
// to the result state. Tick, dispatch and clear-all scan one allocated slot per
// cycle in the scan state; with no allocated slot that state is skipped.
// The next item is taken as soon as the result moves to the output register,
// even while that result waits; a held result stalls only the one after it.
// Reset frees all slots and empties the output; no clearing pass is needed.
module multi_slot_timer_table import mstt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  dp_cmd_t    cmd;
  dp_status_t stat;

  mstt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  mstt_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule
